// ----- sv/dali_pkg.sv -----
// Package: shared types and constants of the DALI master command tracker.
`default_nettype none
package dali_pkg;
	localparam int TABLE_DEPTH = 8;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		CMD_ARC      = 3'd0,
		CMD_COMMAND  = 3'd1,
		CMD_SPECIAL  = 3'd2,
		CMD_EXTENDED = 3'd3,
		CMD_FRAME    = 3'd4,
		CMD_SWEEP    = 3'd5,
		CMD_QUERY    = 3'd6,
		CMD_NONE     = 3'd7
	} cmd_t;

	localparam logic [2:0] ST_WAITING  = 3'd0;
	localparam logic [2:0] ST_SENT     = 3'd1;
	localparam logic [2:0] ST_NOANS    = 3'd2;
	localparam logic [2:0] ST_RECEIVED = 3'd3;
	localparam logic [2:0] ST_NOTREG   = 3'd4;

	localparam logic [2:0] REG_ANSWER_TO  = 3'd0;
	localparam logic [2:0] REG_RELEASE_TO = 3'd1;
	localparam logic [2:0] REG_UNSENT_TO  = 3'd2;
	localparam logic [2:0] REG_INIT_CODE  = 3'd3;
	localparam logic [2:0] REG_RAND_CODE  = 3'd4;
	localparam logic [2:0] REG_ENABLE_TYPE = 3'd5;

	localparam logic [7:0] CFG_CMD_LO = 8'd32;
	localparam logic [7:0] CFG_CMD_HI = 8'd129;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic        is_frame;
		logic [15:0] frame_data;
		logic [31:0] ref_out;
		logic [2:0]  answer_state;
		logic [7:0]  answer_data;
		logic        table_full;
		logic        last;
	} result_t;

	function automatic logic [15:0] build_frame(input logic grp, input logic [5:0] addr,
			input logic sel, input logic [7:0] byte_v);
		build_frame = {grp, addr, sel, byte_v};
	endfunction
endpackage
`default_nettype wire

// ----- sv/dali_cmp.sv -----
// Shared compare unit: age check against a timeout.
`default_nettype none
module dali_cmp (
	input  wire logic [31:0] now_v,
	input  wire logic [31:0] stamp,
	input  wire logic [31:0] limit,
	output logic             expired
);
	logic [31:0] age;
	assign age = now_v - stamp;
	assign expired = age > limit;
endmodule
`default_nettype wire

// ----- sv/dali_master_command_tracker.sv -----
// Top level: frame builder, answer table and the sequencer that scans it entry by entry.
// A request is captured at its accepting edge, then every request scans the answer table one
// entry per cycle through the shared compare unit and a separate release-age compare;
// registration and a query stop in the cycle after the entry they use. Each result is then
// loaded into the output register, and the next request is accepted as soon as the last
// result is loaded. A result held in the output register delays only the next request's
// first result.
`default_nettype none
module dali_master_command_tracker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  command,
	input  wire logic [5:0]  address,
	input  wire logic [7:0]  command_byte,
	input  wire logic [5:0]  special_code,
	input  wire logic [7:0]  value_byte,
	input  wire logic        is_group,
	input  wire logic        want_response,
	input  wire logic [31:0] frame_ref,
	input  wire logic        backward,
	input  wire logic [7:0]  answer_in,
	input  wire logic [31:0] now_us,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             is_frame,
	output logic [15:0]      frame_data,
	output logic [31:0]      ref_out,
	output logic [2:0]       answer_state,
	output logic [7:0]       answer_data,
	output logic             table_full,
	output logic             last
);
	import dali_pkg::*;

	logic [31:0] answer_to_q, release_to_q, unsent_to_q;
	logic [5:0]  init_code_q, rand_code_q, enable_code_q;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [31:0] ref_q  [TABLE_DEPTH];
	logic [31:0] sent_q [TABLE_DEPTH];
	logic [1:0]  stat_q [TABLE_DEPTH];
	logic [7:0]  ans_q  [TABLE_DEPTH];

	state_t state_q, state_d;
	cmd_t   cmd_q;
	logic [31:0] fref_q, now_q;
	logic        bwd_q, want_q, full_q, done_q;
	logic [7:0]  ansin_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	result_t res_q [3];
	logic [1:0]  nres_q, ptr_q;
	logic [31:0] reg_ref_q;
	logic [2:0]  qst_q;
	logic [7:0]  qdata_q;
	result_t out_q;
	logic    outv_q;

	// shared compare operands
	logic [31:0] c_stamp, c_limit;
	logic        c_exp;
	logic [1:0]  cur_stat;
	logic        cur_match;

	assign cur_stat  = stat_q[idx_q];
	assign cur_match = valid_q[idx_q] && ref_q[idx_q] == fref_q;

	always_comb begin
		c_stamp = sent_q[idx_q];
		c_limit = release_to_q;
		if (cur_stat == ST_SENT[1:0]) begin
			c_limit = answer_to_q;
		end else if (cur_stat == ST_WAITING[1:0]) begin
			c_stamp = ref_q[idx_q];
			c_limit = unsent_to_q;
		end
	end

	dali_cmp u_cmp (.now_v(now_q), .stamp(c_stamp), .limit(c_limit), .expired(c_exp));

	// sent entry that just expired: check release against the same stamp in the same cycle
	logic [1:0] sw_stat;
	logic       rel_exp;
	assign sw_stat = (cur_stat == ST_SENT[1:0] && c_exp) ? ST_NOANS[1:0] : cur_stat;
	assign rel_exp = (now_q - sent_q[idx_q]) > release_to_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			answer_to_q   <= 32'd50000;
			release_to_q  <= 32'd100000;
			unsent_to_q   <= 32'd10000000;
			init_code_q   <= 6'd18;
			rand_code_q   <= 6'd19;
			enable_code_q <= 6'd32;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ANSWER_TO:   answer_to_q <= cfg_data;
				REG_RELEASE_TO:  release_to_q <= cfg_data;
				REG_UNSENT_TO:   unsent_to_q <= cfg_data;
				REG_INIT_CODE:   init_code_q <= cfg_data[5:0];
				REG_RAND_CODE:   rand_code_q <= cfg_data[5:0];
				REG_ENABLE_TYPE: enable_code_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	logic last_idx;
	assign last_idx = cnt_q == CNT_W'(TABLE_DEPTH - 1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_SCAN;
			S_SCAN: if (last_idx || done_q) state_d = (nres_q == 2'd0 && cmd_q != CMD_QUERY)
					? S_IDLE : S_EMIT;
			S_EMIT: if (!outv_q || out_ready) state_d = (ptr_q + 2'd1 == nres_q) ? S_IDLE : S_EMIT;
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ready = state_q == S_IDLE;

	logic twice;
	logic [15:0] cframe;
	result_t r0, r1, r2;
	logic [1:0] nres_d;

	always_comb begin
		r0 = '0;
		r1 = '0;
		r2 = '0;
		nres_d = 2'd0;
		twice = 1'b0;
		cframe = 16'd0;
		case (cmd_t'(command))
			CMD_ARC: begin
				r0.is_frame = 1'b1;
				r0.frame_data = build_frame(is_group, address, 1'b0, command_byte);
				nres_d = 2'd1;
			end
			CMD_COMMAND, CMD_EXTENDED, CMD_SPECIAL: begin
				if (cmd_t'(command) == CMD_SPECIAL) begin
					cframe = build_frame(1'b1, special_code, 1'b1, value_byte);
					twice = special_code == init_code_q || special_code == rand_code_q;
				end else begin
					cframe = build_frame(is_group, address, 1'b1, command_byte);
					twice = command_byte >= CFG_CMD_LO && command_byte <= CFG_CMD_HI;
				end
				if (cmd_t'(command) == CMD_EXTENDED) begin
					r0.is_frame = 1'b1;
					r0.frame_data = build_frame(1'b1, enable_code_q, 1'b1, value_byte);
					r0.ref_out = now_us;
					r1.is_frame = 1'b1;
					r1.frame_data = cframe;
					r1.ref_out = now_us;
					r2 = r1;
					r2.ref_out = now_us + 32'd1;
					nres_d = twice ? 2'd3 : 2'd2;
					if (!twice) r2 = r1;
				end else begin
					r0.is_frame = 1'b1;
					r0.frame_data = cframe;
					r0.ref_out = now_us;
					r1 = r0;
					r1.ref_out = now_us + 32'd1;
					nres_d = twice ? 2'd2 : 2'd1;
				end
			end
			default: ;
		endcase
	end

	result_t emit_r;
	logic    emit_last;

	always_comb begin
		emit_last = ptr_q + 2'd1 == nres_q;
		emit_r = res_q[ptr_q];
		if (cmd_q == CMD_QUERY) begin
			emit_r = '0;
			emit_r.ref_out = fref_q;
			emit_r.answer_state = qst_q;
			emit_r.answer_data = qdata_q;
		end
		emit_r.last = emit_last;
		if (emit_last && cmd_q != CMD_QUERY)
			emit_r.table_full = want_q && full_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			outv_q  <= 1'b0;
			idx_q   <= '0;
			cnt_q   <= '0;
			ptr_q   <= '0;
			nres_q  <= '0;
			done_q  <= 1'b0;
			full_q  <= 1'b0;
			cmd_q   <= CMD_NONE;
		end else begin
			if (state_q == S_EMIT && (!outv_q || out_ready)) begin
				outv_q <= 1'b1;
			end else if (out_ready) begin
				outv_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (in_valid) begin
					cmd_q   <= cmd_t'(command);
					fref_q  <= frame_ref;
					now_q   <= now_us;
					bwd_q   <= backward;
					ansin_q <= answer_in;
					want_q  <= want_response && command != CMD_ARC &&
						command <= CMD_EXTENDED;
					res_q[0] <= r0;
					res_q[1] <= r1;
					res_q[2] <= r2;
					nres_q  <= nres_d;
					reg_ref_q <= (nres_d == 2'd1 || (command == CMD_EXTENDED && nres_d == 2'd2))
						? now_us : now_us + 32'd1;
					idx_q   <= '0;
					cnt_q   <= '0;
					ptr_q   <= '0;
					done_q  <= 1'b0;
					full_q  <= 1'b1;
					qst_q   <= ST_NOTREG;
					qdata_q <= 8'd0;
				end
				S_SCAN: begin
					idx_q <= idx_q + IDX_W'(1);
					cnt_q <= cnt_q + CNT_W'(1);
					if (!done_q) begin
						case (cmd_q)
							CMD_COMMAND, CMD_SPECIAL, CMD_EXTENDED: if (want_q && !valid_q[idx_q]) begin
								valid_q[idx_q] <= 1'b1;
								ref_q[idx_q]   <= reg_ref_q;
								sent_q[idx_q]  <= 32'd0;
								stat_q[idx_q]  <= ST_WAITING[1:0];
								ans_q[idx_q]   <= 8'd0;
								full_q <= 1'b0;
								done_q <= 1'b1;
							end
							CMD_FRAME: if (cur_match) begin
								if (bwd_q) begin
									ans_q[idx_q]  <= ansin_q;
									stat_q[idx_q] <= ST_RECEIVED[1:0];
								end else begin
									stat_q[idx_q] <= ST_SENT[1:0];
									sent_q[idx_q] <= now_q;
								end
							end
							CMD_SWEEP: if (valid_q[idx_q]) begin
								stat_q[idx_q] <= sw_stat;
								if (sw_stat == ST_WAITING[1:0]) begin
									if (c_exp) valid_q[idx_q] <= 1'b0;
								end else if (sw_stat != ST_SENT[1:0] && rel_exp) begin
									valid_q[idx_q] <= 1'b0;
								end
							end
							CMD_QUERY: if (cur_match) begin
								qst_q <= {1'b0, cur_stat};
								if (cur_stat == ST_RECEIVED[1:0]) qdata_q <= ans_q[idx_q];
								if (cur_stat == ST_RECEIVED[1:0] || cur_stat == ST_NOANS[1:0])
									valid_q[idx_q] <= 1'b0;
								done_q <= 1'b1;
							end
							default: ;
						endcase
					end
					if (last_idx || done_q) begin
						if (cmd_q == CMD_QUERY) begin
							nres_q <= 2'd1;
						end
					end
				end
				S_EMIT: if (!outv_q || out_ready) begin
					out_q <= emit_r;
					ptr_q <= ptr_q + 2'd1;
				end
				default: ;
			endcase
		end
	end

	assign out_valid    = outv_q;
	assign is_frame     = out_q.is_frame;
	assign frame_data   = out_q.frame_data;
	assign ref_out      = out_q.ref_out;
	assign answer_state = out_q.answer_state;
	assign answer_data  = out_q.answer_data;
	assign table_full   = out_q.table_full;
	assign last         = out_q.last;
endmodule
`default_nettype wire
